### rtl/rbd_pkg.sv
// shared types and constants of the ring buffer deque
package rbd_pkg;

  // fixed field widths of the command and response items
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 7;

  // operation codes, code seven is unused
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_READ_AT    = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

### rtl/rbd_cmd_if.sv
// command channel carrying one deque operation per item
interface rbd_cmd_if import rbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]   position;

  modport source (output valid, operation, item_value, position, input ready);
  modport sink   (input valid, operation, item_value, position, output ready);
endinterface

### rtl/rbd_rsp_if.sv
// response channel carrying one result per item
interface rbd_rsp_if import rbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  logic [STAT_W-1:0]  status;
  logic [FILL_W-1:0]  fill_count;

  modport source (output valid, out_value, status, fill_count, input ready);
  modport sink   (input valid, out_value, status, fill_count, output ready);
endinterface

### rtl/ring_buffer_deque_unit.sv
// ring buffer deque: circular store with front and back pointers and a count
// result path: store read stage, then result register; throughput: one item per
// cycle while the receiver takes results; pointers and count update at the
// accepting edge and the store read is registered, so no forwarding is needed
// reset: pointers, count and pipeline valids cleared; store contents left undefined
module ring_buffer_deque_unit import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbd_cmd_if.sink  cmd_i,
  rbd_rsp_if.source rsp_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned SW   = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  // pointer and count state
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;

  // store and its registered read data
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  // stage holding the item while its store read completes
  logic          a_valid_q;
  logic          a_use_q;
  status_e       a_stat_q;
  logic [FILL_W-1:0] a_fill_q;

  // result register
  logic               rsp_valid_q;
  logic [VALUE_W-1:0] rsp_value_q;
  status_e            rsp_stat_q;
  logic [FILL_W-1:0]  rsp_fill_q;

  logic                  cmd_acc;
  logic                  a_adv;
  op_e                   op;
  logic                  is_empty;
  logic                  is_full;
  logic                  pos_ge;
  logic [SW-1:0]         idx_sum;
  logic [AW-1:0]         idx;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  status_e               stat;
  logic [DATA_WIDTH-1:0] wr_data;

  // handshake
  assign a_adv       = a_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign cmd_i.ready = !a_valid_q || a_adv;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // decode helpers
  assign op       = op_e'(cmd_i.operation);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == FULL_CNT);
  assign pos_ge   = (CMPW'(cmd_i.position) >= CMPW'(count_q));
  assign idx_sum  = SW'(front_q) + SW'(cmd_i.position);
  assign idx      = (idx_sum >= SW'(DEPTH)) ? AW'(idx_sum - SW'(DEPTH)) : AW'(idx_sum);
  assign wr_data  = cmd_i.item_value[DATA_WIDTH-1:0];

  // operation decode: next pointers, count, store access and status
  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = front_q;
    rd_en   = 1'b0;
    rd_addr = front_q;
    stat    = ST_OK;
    unique case (op) inside
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (is_full) begin
          stat = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (is_empty) begin
            front_d = '0;
            back_d  = '0;
            wr_addr = '0;
          end else if (op == OP_PUSH_BACK) begin
            back_d  = slot_next(back_q);
            wr_addr = back_d;
          end else begin
            front_d = slot_prev(front_q);
            wr_addr = front_d;
          end
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (is_empty) begin
          stat = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          count_d = count_q - 1'b1;
          if (op == OP_POP_BACK) begin
            rd_addr = back_q;
            back_d  = slot_prev(back_q);
          end else begin
            rd_addr = front_q;
            front_d = slot_next(front_q);
          end
          // last entry gone: pointers return to slot zero
          if (count_q == CW'(1)) begin
            front_d = '0;
            back_d  = '0;
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (is_empty) begin
          stat = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = (op == OP_PEEK_FRONT) ? front_q : back_q;
        end
      end
      OP_READ_AT: begin
        if (is_empty) begin
          stat = ST_EMPTY;
        end else if (pos_ge) begin
          stat = ST_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx;
        end
      end
      default: begin
      end
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (cmd_acc) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // store write port
  always_ff @(posedge clk_i) begin
    if (cmd_acc && wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // store read port, data held until the next reading item
  always_ff @(posedge clk_i) begin
    if (cmd_acc && rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (cmd_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      a_use_q  <= rd_en;
      a_stat_q <= stat;
      a_fill_q <= FILL_W'(count_d);
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (a_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      rsp_value_q <= a_use_q ? VALUE_W'(rd_data_q) : '0;
      rsp_stat_q  <= a_stat_q;
      rsp_fill_q  <= a_fill_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.out_value  = rsp_value_q;
  assign rsp_o.status     = rsp_stat_q;
  assign rsp_o.fill_count = rsp_fill_q;

  // count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("entry count above depth");

  // an empty queue keeps both pointers at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (front_q == '0 && back_q == '0))
    else $error("empty queue with pointers off slot zero");

  // an accepted push that is not refused grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && wr_en) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not grow the count");

  // one operation never both writes and reads the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en && rd_en))
    else $error("store written and read by one item");

  // an item that reads the store always has status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_use_q) |-> (a_stat_q == ST_OK))
    else $error("store read with non-ok status");

endmodule

### tb/sv/tb_ring_buffer_deque_unit.sv
// self-checking testbench of the ring buffer deque with its own deque predictor
module tb_ring_buffer_deque_unit import rbd_pkg::*; ();

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RUN_CYCLES   = 400000;

  // code seven has no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // one predicted result item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic [FILL_W-1:0]  fill;
  } deq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rbd_cmd_if cmd ();
  rbd_rsp_if rsp ();

  ring_buffer_deque_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // predictor state of the deque
  logic [VALUE_W-1:0] deq_store [DEPTH];
  logic [POS_W-1:0]   deq_front;
  logic [POS_W-1:0]   deq_back;
  logic [FILL_W-1:0]  deq_count;

  deq_result_t pending_results [$];
  int unsigned mismatch_count = 0;

  // idle control of both sides
  bit          send_calm    = 1'b0;
  bit          send_no_idle = 1'b0;
  bit          rsp_calm     = 1'b0;
  int unsigned rsp_stall    = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(8 * RUN_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  // idle draw, switching now and then between calm and busy stretches
  function automatic int unsigned pick_idle(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    if (calm) return 0;
    return $urandom_range(0, 18);
  endfunction

  // deque behavior for one operation, updates the predictor state
  function automatic deq_result_t predict_deque(input logic [OP_W-1:0] op,
                                                input logic [VALUE_W-1:0] value,
                                                input logic [POS_W-1:0] pos);
    deq_result_t      res;
    logic [POS_W-1:0] slot;
    res.value  = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (deq_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (deq_count == 0) begin
            deq_front    = '0;
            deq_back     = '0;
            deq_store[0] = value;
          end else if (op == OP_PUSH_BACK) begin
            deq_back            = deq_back + 1'b1;
            deq_store[deq_back] = value;
          end else begin
            deq_front            = deq_front - 1'b1;
            deq_store[deq_front] = value;
          end
          deq_count = deq_count + 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (deq_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_BACK) begin
            res.value = deq_store[deq_back];
            deq_back  = deq_back - 1'b1;
          end else begin
            res.value = deq_store[deq_front];
            deq_front = deq_front + 1'b1;
          end
          deq_count = deq_count - 1'b1;
          // last entry gone, pointers go home
          if (deq_count == 0) begin
            deq_front = '0;
            deq_back  = '0;
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (deq_count == 0) res.status = ST_EMPTY;
        else res.value = deq_store[(op == OP_PEEK_FRONT) ? deq_front : deq_back];
      end
      OP_READ_AT: begin
        slot = deq_front + pos;
        if (deq_count == 0) res.status = ST_EMPTY;
        else if (pos >= deq_count) res.status = ST_RANGE;
        else res.value = deq_store[slot];
      end
      default: ;
    endcase
    res.fill = deq_count;
    return res;
  endfunction

  // mismatch report
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
  endtask

  // send one item and record its expected result at the accepting edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    int unsigned idle;
    cmd.valid      <= 1'b1;
    cmd.operation  <= op;
    cmd.item_value <= value;
    cmd.position   <= pos;
    do @(posedge clk_i); while (!cmd.ready);
    pending_results.push_back(predict_deque(op, value, pos));
    idle = send_no_idle ? 0 : pick_idle(send_calm);
    if (idle != 0) begin
      cmd.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver ready with random stalls between items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      rsp_stall = pick_idle(rsp_calm);
      rsp.ready <= (rsp_stall == 0);
    end else if (rsp_stall != 0) begin
      rsp_stall = rsp_stall - 1;
      rsp.ready <= (rsp_stall == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    deq_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", rsp.out_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.out_value !== want.value)
          report_mismatch("out_value", rsp.out_value, want.value);
        if (rsp.status !== want.status)
          report_mismatch("status", VALUE_W'(rsp.status), VALUE_W'(want.status));
        if (rsp.fill_count !== want.fill)
          report_mismatch("fill_count", VALUE_W'(rsp.fill_count), VALUE_W'(want.fill));
      end
    end
  end

  // every pop, peek and read operation on an empty queue, plus the unused code
  task automatic test_empty_queue();
    send_op(OP_POP_BACK, '1, '1);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_PEEK_FRONT, '0, '0);
    send_op(OP_PEEK_BACK, '0, '0);
    send_op(OP_READ_AT, '0, '0);
    send_op(OP_UNUSED, '1, '1);
  endtask

  // pushes at both ends, the front wrapping below slot zero, reads and pops
  task automatic test_basic_ops();
    send_op(OP_PUSH_BACK, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_op(OP_PUSH_FRONT, 64'h0000_0000_0000_0000, '0);
    send_op(OP_PUSH_BACK, 64'hA5A5_5A5A_0123_4567, '1);
    send_op(OP_PUSH_FRONT, 64'h8000_0000_0000_0001, '0);
    send_op(OP_PEEK_FRONT, '0, '0);
    send_op(OP_PEEK_BACK, '0, '0);
    send_op(OP_READ_AT, '0, 6'd0);
    send_op(OP_READ_AT, '0, 6'd3);
    send_op(OP_READ_AT, '0, 6'd4);
    send_op(OP_READ_AT, '0, 6'd63);
    send_op(OP_UNUSED, '0, '0);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_POP_BACK, '0, '0);
  endtask

  // fill to the top, refused pushes at both ends, then drain
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value(), 6'($urandom));
    send_op(OP_PUSH_BACK, '1, '0);
    send_op(OP_PUSH_FRONT, '1, '0);
    send_op(OP_READ_AT, '0, 6'd63);
    send_op(OP_READ_AT, '0, 6'd0);
    send_op(OP_PEEK_FRONT, '0, '0);
    send_op(OP_PEEK_BACK, '0, '0);
    for (int i = 0; i < DEPTH; i++)
      send_op($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, '0, 6'($urandom));
    send_op(OP_POP_FRONT, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure(input int unsigned count);
    send_no_idle = 1'b1;
    hold_req <= hold_req + 1;
    for (int unsigned i = 0; i < count; i++)
      send_op($urandom_range(0, 2) != 0 ? OP_PUSH_BACK : OP_POP_FRONT, rand_value(),
              6'($urandom));
    send_no_idle = 1'b0;
  endtask

  // random operations in growing, shrinking and balanced stretches
  task automatic test_random_ops(input int unsigned count);
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    int unsigned      push_pct;
    int unsigned      pick;
    push_pct = 45;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 20;
          default: push_pct = 45;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else if (pick < 97) begin
        case ($urandom_range(0, 5))
          0:       op = OP_POP_BACK;
          1:       op = OP_POP_FRONT;
          2:       op = OP_PEEK_FRONT;
          3:       op = OP_PEEK_BACK;
          default: op = OP_READ_AT;
        endcase
      end else begin
        op = OP_UNUSED;
      end
      // reads mostly land on a held entry
      if (deq_count != 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, deq_count - 1));
      else
        pos = POS_W'($urandom);
      send_op(op, rand_value(), pos);
    end
  endtask

  // reset, test sequence and final verdict
  initial begin
    rst_ni         = 1'b0;
    cmd.valid      = 1'b0;
    cmd.operation  = '0;
    cmd.item_value = '0;
    cmd.position   = '0;
    deq_front      = '0;
    deq_back       = '0;
    deq_count      = '0;
    for (int i = 0; i < DEPTH; i++) deq_store[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_basic_ops();
    test_full_queue();
    test_backpressure(60);
    test_random_ops(1500);

    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/rbd_pkg.sv
rtl/rbd_cmd_if.sv
rtl/rbd_rsp_if.sv
rtl/ring_buffer_deque_unit.sv
tb/sv/tb_ring_buffer_deque_unit.sv
